// ===== rtl/lcg_rs_pkg.sv =====
package lcg_rs_pkg;

  // Generator constants
  localparam logic [63:0] LCG_MUL      = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC      = 64'd1442695040888963407;
  localparam logic [63:0] DEFAULT_SEED = 64'd123456789;

  // Fraction is the top FRAC_W bits of the state
  localparam int unsigned STATE_W    = 64;
  localparam int unsigned FRAC_W     = 53;
  localparam int unsigned FRAC_SHIFT = STATE_W - FRAC_W;
  localparam int unsigned BOUND_W    = 32;
  localparam int unsigned SPAN_W     = BOUND_W + 1;

  // Digit-serial multiplier: one DIGIT_W-bit multiplier digit per cycle
  localparam int unsigned DIGIT_W     = 8;
  localparam int unsigned LCG_STEPS   = STATE_W / DIGIT_W;
  localparam int unsigned SCALE_STEPS = (SPAN_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned CNT_W       = $clog2(LCG_STEPS);

  // After SCALE_STEPS digits the product sits in {hi, lo[top]};
  // product >> FRAC_W starts at this bit of hi
  localparam int unsigned SCALE_LSB = FRAC_W - (SCALE_STEPS * DIGIT_W);

  typedef enum logic [1:0] {
    KIND_NEXT   = 2'd0,
    KIND_RESEED = 2'd1,
    KIND_REPEAT = 2'd2,
    KIND_RANGE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INC,
    ST_SCALE,
    ST_DONE
  } state_e;

  // Multiplier control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

endpackage

// ===== rtl/lcg_random_with_range_scaling.sv =====
// Random number unit: 64-bit linear congruential generator with range scaling.
// Input channel (in_valid_i/in_ready_o) carries one request item: kind, seed,
// and two range bounds. Output channel (out_valid_o/out_ready_i) returns one
// result item per request: 53-bit fraction, range value and integer flag.
// Steps from acceptance to result:
//   repeat last:       straight to the finish step
//   next / reseed:     8 multiplier digits, increment, finish
//   integer range:     adds 5 digits of the scaling multiply
// One request is in flight at a time. The next item can be accepted in the cycle
// after the result is loaded. Both multiplies run on one shared 64x8
// digit-serial multiplier. The result sits in an output register, so a new
// request is accepted while the previous result waits for the receiver. If the
// receiver stalls with a result still held, the finished item waits in the
// finish step until the output register frees up. Reset (rst_ni low,
// asynchronous) sets the generator state to 123456789, the last fraction to
// zero and empties the output register.
module lcg_random_with_range_scaling (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [62:0]         seed_value_i,
  input  logic signed [31:0]  bound_a_i,
  input  logic signed [31:0]  bound_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [52:0]         fraction_o,
  output logic signed [31:0]  range_value_o,
  output logic                is_integer_o
);
  import lcg_rs_pkg::*;

  state_e                    st_q, st_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  kind_e                     kind_q, kind_d;
  logic [STATE_W-1:0]        gen_q, gen_d;
  logic [FRAC_W-1:0]         last_q, last_d;
  logic signed [BOUND_W-1:0] lo_q, lo_d;
  logic signed [BOUND_W-1:0] hi_q, hi_d;
  logic [SPAN_W-1:0]         span_q, span_d;

  mul_ctrl_t                 mul_ctrl;
  logic [STATE_W-1:0]        mcand, mplier;
  logic [STATE_W-1:0]        mul_hi, mul_lo;
  logic [STATE_W-1:0]        next_state;
  logic [STATE_W-1:0]        seed_ext;
  logic                      accept, out_free, out_load;
  logic                      a_lt_b;
  logic signed [SPAN_W-1:0]  lo_ext, hi_ext, sum_r;
  logic [BOUND_W-1:0]        scaled;
  logic signed [BOUND_W-1:0] range_res;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == ST_IDLE);

  // Seed zero maps to the default seed
  assign seed_ext = (seed_value_i == '0) ? DEFAULT_SEED : {1'b0, seed_value_i};

  // Bound ordering
  assign a_lt_b = (bound_a_i < bound_b_i);

  // Low 64 bits of the product plus increment
  assign next_state = mul_lo + LCG_INC;

  // Scaled offset is product >> 53, below span so it fits 32 bits
  assign scaled = mul_hi[SCALE_LSB +: BOUND_W];
  assign lo_ext = {lo_q[BOUND_W-1], lo_q};
  assign hi_ext = {hi_q[BOUND_W-1], hi_q};
  assign sum_r  = lo_ext + $signed({1'b0, scaled});

  // Clamp to high bound
  always_comb begin
    if (sum_r > hi_ext) begin
      range_res = hi_q;
    end else begin
      range_res = sum_r[BOUND_W-1:0];
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          st_d = (kind_e'(kind_i) == KIND_REPEAT) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(LCG_STEPS - 1)) begin
          st_d = ST_INC;
        end
      end
      ST_INC: begin
        st_d = (kind_q == KIND_RANGE) ? ST_SCALE : ST_DONE;
      end
      ST_SCALE: begin
        if (cnt_q == CNT_W'(SCALE_STEPS - 1)) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    cnt_d    = cnt_q;
    kind_d   = kind_q;
    gen_d    = gen_q;
    last_d   = last_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    span_d   = span_q;
    mul_ctrl = '0;
    mcand    = LCG_MUL;
    mplier   = gen_q;
    out_load = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          kind_d        = kind_e'(kind_i);
          lo_d          = a_lt_b ? bound_a_i : bound_b_i;
          hi_d          = a_lt_b ? bound_b_i : bound_a_i;
          span_d        = SPAN_W'({hi_d[BOUND_W-1], hi_d} - {lo_d[BOUND_W-1], lo_d})
                          + SPAN_W'(1);
          mul_ctrl.load = 1'b1;
          mplier        = (kind_e'(kind_i) == KIND_RESEED) ? seed_ext : gen_q;
        end
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
      end
      ST_INC: begin
        gen_d         = next_state;
        last_d        = next_state[STATE_W-1:FRAC_SHIFT];
        cnt_d         = '0;
        mul_ctrl.load = (kind_q == KIND_RANGE);
        mcand         = {{FRAC_SHIFT{1'b0}}, next_state[STATE_W-1:FRAC_SHIFT]};
        mplier        = {{(STATE_W-SPAN_W){1'b0}}, span_q};
      end
      ST_SCALE: begin
        mul_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // Control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      gen_q  <= DEFAULT_SEED;
      last_q <= '0;
      kind_q <= KIND_NEXT;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      gen_q  <= gen_d;
      last_q <= last_d;
      kind_q <= kind_d;
    end
  end

  // Request operands
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    span_q <= span_d;
  end

  lcg_rs_mul u_mul (
    .clk_i    (clk_i),
    .ctrl_i   (mul_ctrl),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .hi_o     (mul_hi),
    .lo_o     (mul_lo)
  );

  lcg_rs_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .fraction_i    (last_q),
    .range_value_i ((kind_q == KIND_RANGE) ? range_res : '0),
    .is_integer_i  (kind_q == KIND_RANGE),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fraction_o    (fraction_o),
    .range_value_o (range_value_o),
    .is_integer_o  (is_integer_o)
  );

endmodule

// ===== rtl/lcg_rs_mul.sv =====
module lcg_rs_mul (
  input  logic                   clk_i,
  input  lcg_rs_pkg::mul_ctrl_t  ctrl_i,
  input  logic [63:0]            mcand_i,
  input  logic [63:0]            mplier_i,
  output logic [63:0]            hi_o,
  output logic [63:0]            lo_o
);
  import lcg_rs_pkg::*;

  logic [STATE_W-1:0]         mc_q, mc_d;
  logic [STATE_W-1:0]         hi_q, hi_d;
  logic [STATE_W-1:0]         lo_q, lo_d;
  logic [STATE_W+DIGIT_W-1:0] sum;

  // One partial product per cycle while step is set, added into the upper half
  assign sum = {{DIGIT_W{1'b0}}, hi_q} + mc_q * lo_q[DIGIT_W-1:0];

  // Load operands or shift the product right by one digit
  always_comb begin
    mc_d = mc_q;
    hi_d = hi_q;
    lo_d = lo_q;
    if (ctrl_i.load) begin
      mc_d = mcand_i;
      hi_d = '0;
      lo_d = mplier_i;
    end else if (ctrl_i.step) begin
      hi_d = sum[STATE_W+DIGIT_W-1:DIGIT_W];
      lo_d = {sum[DIGIT_W-1:0], lo_q[STATE_W-1:DIGIT_W]};
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    mc_q <= mc_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

// ===== rtl/lcg_rs_out.sv =====
module lcg_rs_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [52:0]         fraction_i,
  input  logic signed [31:0]  range_value_i,
  input  logic                is_integer_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [52:0]         fraction_o,
  output logic signed [31:0]  range_value_o,
  output logic                is_integer_o
);
  import lcg_rs_pkg::*;

  logic                      valid_q, valid_d;
  logic [FRAC_W-1:0]         frac_q;
  logic signed [BOUND_W-1:0] range_q;
  logic                      int_q;

  // Slot takes a new item once empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frac_q  <= fraction_i;
      range_q <= range_value_i;
      int_q   <= is_integer_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign fraction_o    = frac_q;
  assign range_value_o = range_q;
  assign is_integer_o  = int_q;

endmodule
